// ----- sv/uart_tx_frame_serializer_assert.svh -----
// Assertion macros for the serializer modules; utx_frame includes them.
// Each macro checks a property on the rising clock edge; UTX_ASSERT is turned off
// while the active-low reset is asserted, UTX_ASSERT_ALWAYS is not.
`ifndef UART_TX_FRAME_SERIALIZER_ASSERT_SVH
`define UART_TX_FRAME_SERIALIZER_ASSERT_SVH

`ifndef SYNTH
`define UTX_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("uart_tx_frame_serializer assertion failed");
`define UTX_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("uart_tx_frame_serializer assertion failed");
`else
`define UTX_ASSERT(label, clk, rst_n, prop)
`define UTX_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ----- sv/utx_pkg.sv -----
`timescale 1ns / 1ps

package utx_pkg;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 3;
    localparam int INDEX_W = 2;
    localparam int DATA_W  = 4;
    localparam int STEP_W  = 4;

    localparam logic [KIND_W-1:0] KIND_START  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DATA   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PARITY = 3'd2;
    localparam logic [KIND_W-1:0] KIND_STOP   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PAD    = 3'd4;

    localparam logic [INDEX_W-1:0] REG_DATA_LEN  = 2'd0;
    localparam logic [INDEX_W-1:0] REG_PARITY    = 2'd1;
    localparam logic [INDEX_W-1:0] REG_STOP_BITS = 2'd2;

    localparam logic [1:0] PAR_NONE = 2'd0;
    localparam logic [1:0] PAR_ODD  = 2'd1;
    localparam logic [1:0] PAR_EVEN = 2'd2;

    localparam logic [3:0] DATA_LEN_MIN    = 4'd5;
    localparam logic [3:0] DATA_LEN_MAX    = 4'd9;
    localparam logic [3:0] DATA_LEN_RESET  = 4'd8;
    localparam logic [1:0] STOP_BITS_RESET = 2'd1;

    typedef struct packed {
        logic [3:0] data_len;
        logic       parity_en;
        logic       parity_odd;
        logic       two_stop;
    } t_frame_cfg;

    typedef struct packed {
        logic              level;
        logic [KIND_W-1:0] kind;
        logic              last;
    } t_result;

endpackage

// ----- sv/utx_channels.sv -----
`timescale 1ns / 1ps

interface utx_byte_if;
    logic                       valid;
    logic                       ready;
    logic [utx_pkg::BYTE_W-1:0] tx_byte;

    modport source (output valid, output tx_byte, input ready);
    modport sink (input valid, input tx_byte, output ready);
endinterface

interface utx_bit_if;
    logic                       valid;
    logic                       ready;
    logic                       line_level;
    logic [utx_pkg::KIND_W-1:0] bit_kind;
    logic                       frame_end;

    modport source (output valid, output line_level, output bit_kind, output frame_end,
                    input ready);
    modport sink (input valid, input line_level, input bit_kind, input frame_end,
                  output ready);
endinterface

interface utx_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [utx_pkg::INDEX_W-1:0] index;
    logic [utx_pkg::DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- sv/utx_cfg.sv -----
`timescale 1ns / 1ps

module utx_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    utx_cfg_if.sink             i_cfg,
    output utx_pkg::t_frame_cfg o_cfg
);

    logic [3:0] r_data_len;
    logic [1:0] r_parity;
    logic [1:0] r_stop_bits;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_len  <= utx_pkg::DATA_LEN_RESET;
            r_parity    <= utx_pkg::PAR_NONE;
            r_stop_bits <= utx_pkg::STOP_BITS_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                utx_pkg::REG_DATA_LEN:  r_data_len  <= i_cfg.data;
                utx_pkg::REG_PARITY:    r_parity    <= i_cfg.data[1:0];
                utx_pkg::REG_STOP_BITS: r_stop_bits <= i_cfg.data[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_data_len < utx_pkg::DATA_LEN_MIN) begin
            o_cfg.data_len = utx_pkg::DATA_LEN_MIN;
        end else if (r_data_len > utx_pkg::DATA_LEN_MAX) begin
            o_cfg.data_len = utx_pkg::DATA_LEN_MAX;
        end else begin
            o_cfg.data_len = r_data_len;
        end
        o_cfg.parity_en  = (r_parity == utx_pkg::PAR_ODD) || (r_parity == utx_pkg::PAR_EVEN);
        o_cfg.parity_odd = (r_parity == utx_pkg::PAR_ODD);
        o_cfg.two_stop   = r_stop_bits[1];
    end

endmodule

// ----- sv/utx_frame.sv -----
`timescale 1ns / 1ps

`include "uart_tx_frame_serializer_assert.svh"

module utx_frame (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  utx_pkg::t_frame_cfg i_cfg,
    utx_byte_if.sink            i_byte,
    input  logic                i_out_free,
    output logic                o_advance,
    output utx_pkg::t_result    o_result
);

    logic                       r_busy;
    logic [utx_pkg::STEP_W-1:0] r_step;
    logic [utx_pkg::BYTE_W-1:0] r_byte;
    logic                       r_parity;

    logic                       w_extra;
    logic [utx_pkg::STEP_W-1:0] w_extra_pos;
    logic [utx_pkg::STEP_W-1:0] w_len;
    logic [utx_pkg::STEP_W-1:0] w_last_pos;
    logic [utx_pkg::STEP_W-1:0] w_data_idx;
    logic                       w_accept;

    assign w_extra     = i_cfg.parity_en || (i_cfg.data_len == utx_pkg::DATA_LEN_MAX);
    assign w_extra_pos = i_cfg.data_len + 4'd1;
    assign w_len       = 4'd2 + i_cfg.data_len + {3'b000, w_extra} + {3'b000, i_cfg.two_stop};
    assign w_last_pos  = w_len - 4'd1;
    assign w_data_idx  = r_step - 4'd1;

    assign o_advance    = r_busy && i_out_free;
    assign i_byte.ready = !r_busy || (o_advance && o_result.last);
    assign w_accept     = i_byte.valid && i_byte.ready;

    always_comb begin
        o_result.last = (r_step == w_last_pos);
        if (r_step == '0) begin
            o_result.kind  = utx_pkg::KIND_START;
            o_result.level = 1'b0;
        end else if (r_step <= i_cfg.data_len) begin
            o_result.kind  = utx_pkg::KIND_DATA;
            o_result.level = w_data_idx[3] ? 1'b0 : r_byte[w_data_idx[2:0]];
        end else if (w_extra && (r_step == w_extra_pos)) begin
            if (i_cfg.parity_en) begin
                o_result.kind  = utx_pkg::KIND_PARITY;
                o_result.level = r_parity;
            end else begin
                o_result.kind  = utx_pkg::KIND_PAD;
                o_result.level = 1'b0;
            end
        end else begin
            o_result.kind  = utx_pkg::KIND_STOP;
            o_result.level = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (w_accept) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (o_advance) begin
            if (o_result.last) begin
                r_busy <= 1'b0;
                r_step <= '0;
            end else begin
                r_step <= r_step + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_byte   <= i_byte.tx_byte;
            r_parity <= (^i_byte.tx_byte) ^ i_cfg.parity_odd;
        end
    end

    `UTX_ASSERT(a_step_in_frame, i_clk, i_rst_n, r_busy |-> (r_step <= w_last_pos))
    `UTX_ASSERT(a_step_holds, i_clk, i_rst_n, (r_busy && !o_advance) |=> $stable(r_step))
    `UTX_ASSERT(a_frame_restarts, i_clk, i_rst_n, (o_advance && o_result.last) |=> (r_step == '0))
    `UTX_ASSERT_ALWAYS(a_idle_step_zero, i_clk, (!r_busy && i_rst_n) |-> (r_step == '0))

endmodule

// ----- sv/utx_out.sv -----
`timescale 1ns / 1ps

module utx_out (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  utx_pkg::t_result i_result,
    output logic             o_free,
    utx_bit_if.source        o_bit
);

    logic             r_valid;
    utx_pkg::t_result r_result;

    assign o_free = !r_valid || o_bit.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_bit.valid      = r_valid;
    assign o_bit.line_level = r_result.level;
    assign o_bit.bit_kind   = r_result.kind;
    assign o_bit.frame_end  = r_result.last;

endmodule

// ----- sv/uart_tx_frame_serializer.sv -----
`timescale 1ns / 1ps

// UART transmit frame serializer.
// i_byte carries one byte per request; o_bit returns the frame for that byte as
// one request per bit period: start, data bits LSB first, optional parity or
// padding period, then one or two stop bits, with frame_end set on the last.
// i_cfg writes data_bit_count (index 0), parity_mode (1) and stop_bit_count (2);
// it is always ready and should be used only while no frame is in flight.
// A taken byte is registered, and each bit reaches o_bit via the output register.
// A frame holds 7 to 13 bits, counted by the frame step counter, and is issued
// one bit per cycle while o_bit is not stalled; the next byte is taken in the cycle
// its predecessor's last bit is issued, so frames follow each other without gaps.
// When o_bit is stalled, the output register holds its bit and the frame
// counter waits; i_byte is not ready until the current frame's last bit moves.
// Synchronous reset empties the output register, drops any frame in progress
// and restores 8 data bits, no parity and one stop bit.
module uart_tx_frame_serializer (
    input logic       i_clk,
    input logic       i_rst_n,
    utx_byte_if.sink  i_byte,
    utx_cfg_if.sink   i_cfg,
    utx_bit_if.source o_bit
);

    utx_pkg::t_frame_cfg w_cfg;
    utx_pkg::t_result    w_result;
    logic                w_advance;
    logic                w_out_free;

    utx_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    utx_frame u_frame (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_byte     (i_byte),
        .i_out_free (w_out_free),
        .o_advance  (w_advance),
        .o_result   (w_result)
    );

    utx_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_advance),
        .i_result (w_result),
        .o_free   (w_out_free),
        .o_bit    (o_bit)
    );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import utx_pkg::*;

    localparam int NUM_PHASES   = 19;
    localparam int RANDOM_ITEMS = 38;
    localparam int DRAIN_CYCLES = 4;
    localparam int CYCLE_LIMIT  = 300000;

    localparam logic [INDEX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic [INDEX_W-1:0] index;
        logic [DATA_W-1:0]  value;
    } t_reg_write;

    logic i_clk;
    logic i_rst_n;

    utx_byte_if byte_ch ();
    utx_bit_if  bit_ch ();
    utx_cfg_if  cfg_ch ();

    uart_tx_frame_serializer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .i_cfg   (cfg_ch),
        .o_bit   (bit_ch)
    );

    logic [BYTE_W-1:0] pending_bytes[$];
    t_result           expected_bits[$];
    t_reg_write        reg_writes[$];
    logic [BYTE_W-1:0] corner_bytes[$] = '{
        8'h00, 8'hFF, 8'h01, 8'h80,
        8'hFF, 8'h00, 8'h01,
        8'h00, 8'hFF, 8'h80,
        8'h01, 8'hFE, 8'h55,
        8'hAA, 8'h7F, 8'h00,
        8'hFF, 8'h55, 8'h81,
        8'h00, 8'hFF, 8'h96
    };

    logic [3:0] cfg_data_len;
    logic [1:0] cfg_parity;
    logic [1:0] cfg_stop_bits;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int failures      = 0;
    int cycle_count   = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void push_bit(input logic level, input logic [KIND_W-1:0] kind,
                                     input logic last);
        t_result r;
        r.level = level;
        r.kind  = kind;
        r.last  = last;
        expected_bits.push_back(r);
    endfunction

    function automatic void predict_frame(input logic [BYTE_W-1:0] tx);
        int   n_data;
        int   n_stop;
        logic level;
        n_data = (cfg_data_len < DATA_LEN_MIN) ? int'(DATA_LEN_MIN) :
                 (cfg_data_len > DATA_LEN_MAX) ? int'(DATA_LEN_MAX) : int'(cfg_data_len);
        n_stop = (cfg_stop_bits < 2'd1) ? 1 : (cfg_stop_bits > 2'd2) ? 2 : int'(cfg_stop_bits);
        level  = 1'b0;
        push_bit(1'b0, KIND_START, 1'b0);
        for (int i = 0; i < n_data; i++) begin
            level = (i < BYTE_W) ? tx[i] : 1'b0;
            push_bit(level, KIND_DATA, 1'b0);
        end
        if (cfg_parity == PAR_ODD) begin
            push_bit(~^tx, KIND_PARITY, 1'b0);
        end else if (cfg_parity == PAR_EVEN) begin
            push_bit(^tx, KIND_PARITY, 1'b0);
        end else if (n_data == int'(DATA_LEN_MAX)) begin
            push_bit(level, KIND_PAD, 1'b0);
        end
        for (int s = 1; s <= n_stop; s++) begin
            push_bit(1'b1, KIND_STOP, s == n_stop);
        end
    endfunction

    function automatic void apply_reg_write(input t_reg_write w);
        case (w.index)
            REG_DATA_LEN: begin
                cfg_data_len = w.value;
            end
            REG_PARITY: begin
                cfg_parity = w.value[1:0];
            end
            REG_STOP_BITS: begin
                cfg_stop_bits = w.value[1:0];
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void queue_write(input logic [INDEX_W-1:0] index,
                                        input logic [DATA_W-1:0] value);
        t_reg_write w;
        w.index = index;
        w.value = value;
        reg_writes.push_back(w);
    endfunction

    always @(posedge i_clk) begin : byte_driver
        if (!i_rst_n) begin
            byte_ch.valid <= 1'b0;
        end else begin
            if (byte_ch.valid && byte_ch.ready) begin
                predict_frame(byte_ch.tx_byte);
            end
            if (byte_ch.valid && !byte_ch.ready) begin
            end else if (pending_bytes.size() > 0 &&
                         $urandom_range(0, 99) >= send_idle_pct) begin
                byte_ch.valid   <= 1'b1;
                byte_ch.tx_byte <= pending_bytes.pop_front();
            end else begin
                byte_ch.valid   <= 1'b0;
                byte_ch.tx_byte <= BYTE_W'($urandom);
            end
        end
    end

    always @(posedge i_clk) begin : bit_monitor
        t_result want;
        if (i_rst_n && bit_ch.valid && bit_ch.ready) begin
            if (expected_bits.size() == 0) begin
                $error("unexpected bit request: line_level %0d bit_kind %0d frame_end %0d",
                       bit_ch.line_level, bit_ch.bit_kind, bit_ch.frame_end);
                failures++;
            end else begin
                want = expected_bits.pop_front();
                if (bit_ch.line_level !== want.level) begin
                    $error("line_level: expected %0d, actual %0d", want.level,
                           bit_ch.line_level);
                    failures++;
                end
                if (bit_ch.bit_kind !== want.kind) begin
                    $error("bit_kind: expected %0d, actual %0d", want.kind, bit_ch.bit_kind);
                    failures++;
                end
                if (bit_ch.frame_end !== want.last) begin
                    $error("frame_end: expected %0d, actual %0d", want.last,
                           bit_ch.frame_end);
                    failures++;
                end
            end
        end
        bit_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_bytes.size() > 0 || byte_ch.valid || expected_bits.size() > 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_registers();
        t_reg_write w;
        while (reg_writes.size() > 0) begin
            w = reg_writes.pop_front();
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= w.index;
            cfg_ch.data  <= w.value;
            do @(posedge i_clk); while (!cfg_ch.ready);
            apply_reg_write(w);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_phase(input int phase, input int n_items, input bit corner);
        int mode;
        if (phase > 0) begin
            wait_idle();
        end
        mode = phase * 3 / NUM_PHASES;
        send_idle_pct = (mode == 0) ? 29 : (mode == 1) ? 72 : 0;
        recv_idle_pct = (mode == 0) ? 72 : (mode == 1) ? 29 : 0;
        write_registers();
        for (int i = 0; i < n_items; i++) begin
            if (corner) begin
                pending_bytes.push_back(corner_bytes.pop_front());
            end else begin
                pending_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        logic [DATA_W-1:0] value;
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        byte_ch.valid  = 1'b0;
        byte_ch.tx_byte = '0;
        bit_ch.ready   = 1'b0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = '0;
        cfg_ch.data    = '0;
        cfg_data_len   = DATA_LEN_RESET;
        cfg_parity     = PAR_NONE;
        cfg_stop_bits  = STOP_BITS_RESET;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_phase(0, 4, 1'b1);

        queue_write(REG_DATA_LEN, 4'd9);
        queue_write(REG_PARITY, {2'b00, PAR_NONE});
        queue_write(REG_STOP_BITS, 4'd2);
        run_phase(1, 3, 1'b1);

        queue_write(REG_DATA_LEN, 4'd5);
        queue_write(REG_PARITY, {2'b00, PAR_ODD});
        queue_write(REG_STOP_BITS, 4'd1);
        run_phase(2, 3, 1'b1);

        queue_write(REG_DATA_LEN, 4'd9);
        queue_write(REG_PARITY, {2'b00, PAR_EVEN});
        queue_write(REG_STOP_BITS, 4'd2);
        run_phase(3, 3, 1'b1);

        queue_write(REG_DATA_LEN, 4'd15);
        queue_write(REG_PARITY, 4'hF);
        queue_write(REG_STOP_BITS, 4'hC);
        queue_write(REG_UNUSED, 4'hA);
        run_phase(4, 3, 1'b1);

        queue_write(REG_DATA_LEN, 4'd0);
        queue_write(REG_PARITY, {2'b01, PAR_ODD});
        queue_write(REG_STOP_BITS, 4'd3);
        run_phase(5, 3, 1'b1);

        queue_write(REG_DATA_LEN, 4'd4);
        queue_write(REG_PARITY, {2'b10, PAR_EVEN});
        queue_write(REG_STOP_BITS, 4'd1);
        queue_write(REG_UNUSED, 4'h5);
        run_phase(6, 3, 1'b1);

        for (int p = 7; p < NUM_PHASES; p++) begin
            value = ($urandom_range(0, 9) == 0) ? DATA_W'($urandom_range(0, 15))
                                                : DATA_W'($urandom_range(5, 9));
            queue_write(REG_DATA_LEN, value);
            value = {2'($urandom_range(0, 3)), 2'($urandom_range(0, 3))};
            queue_write(REG_PARITY, value);
            value = {2'($urandom_range(0, 3)),
                     ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3))
                                                 : 2'($urandom_range(1, 2))};
            queue_write(REG_STOP_BITS, value);
            if ($urandom_range(0, 3) == 0) begin
                queue_write(REG_UNUSED, DATA_W'($urandom));
            end
            run_phase(p, RANDOM_ITEMS, 1'b0);
        end

        wait_idle();
        if (failures == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- uart_tx_frame_serializer.f -----
+incdir+sv
sv/utx_pkg.sv
sv/utx_channels.sv
sv/utx_cfg.sv
sv/utx_frame.sv
sv/utx_out.sv
sv/uart_tx_frame_serializer.sv
tb/tb_top.sv
